// ===== rtl/framebuffer_region_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// framebuffer region engine assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_REGION_ENGINE_TOP_ASSERT_SVH
`define FRAMEBUFFER_REGION_ENGINE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FRE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framebuffer region engine: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define FRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framebuffer region engine: next-cycle check failed");

`endif

// ===== rtl/fre_pkg.sv =====
// ----------------------------------------------------------------------------
// fre_pkg
// types, codes and sizes shared by the framebuffer region engine
// ----------------------------------------------------------------------------
`default_nettype none

package fre_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int CNT_W       = $clog2(STORE_WORDS + 1);

  localparam int X_W     = 8;
  localparam int Y_W     = 7;
  localparam int CMD_W   = 3;
  localparam int COLOR_W = 16;
  localparam int FULL_W  = 16;   // y*pitch+x, largest 127*255+255
  localparam int PROD_W  = 15;   // width*height
  localparam int IDX_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HLINE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SC_UP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SC_DN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_PITCH  = 2'd2;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FILL,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  // one access to the pixel store
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic               lin;
    logic [ADDR_W-1:0]  lin_addr;
    logic [Y_W-1:0]     row;
    logic [X_W-1:0]     column;
    logic [COLOR_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/fre_store.sv =====
// ----------------------------------------------------------------------------
// fre_store
// pixel store with row/column address generation and range checking
// ----------------------------------------------------------------------------
`default_nettype none

module fre_store (
  input  wire logic                      clk,
  input  wire fre_pkg::mem_req_t         req,
  input  wire logic [fre_pkg::X_W-1:0]   pitch,
  output logic      [fre_pkg::COLOR_W-1:0] rdata
);

  logic [fre_pkg::COLOR_W-1:0] store_mem [fre_pkg::STORE_WORDS];
  logic [fre_pkg::FULL_W-1:0]  full_addr;
  logic [fre_pkg::ADDR_W-1:0]  addr;
  logic                        in_range;
  logic [fre_pkg::COLOR_W-1:0] rdata_r;
  logic                        ok_r;

  assign full_addr = fre_pkg::FULL_W'(req.row) * fre_pkg::FULL_W'(pitch)
                   + fre_pkg::FULL_W'(req.column);

  always_comb begin
    if (req.lin) begin
      addr     = req.lin_addr;
      in_range = 1'b1;
    end else begin
      addr     = full_addr[fre_pkg::ADDR_W-1:0];
      in_range = (32'(full_addr) < fre_pkg::STORE_WORDS);
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr && in_range) begin
      store_mem[addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata_r <= store_mem[addr];
      ok_r    <= in_range;
    end
  end

  // words past the end of the store read as zero
  assign rdata = ok_r ? rdata_r : '0;

endmodule

`default_nettype wire

// ===== rtl/framebuffer_region_engine_top.sv =====
// ----------------------------------------------------------------------------
// framebuffer_region_engine_top
// scroll and fill engine over a 16-bit pixel store, one request at a time
// ----------------------------------------------------------------------------
// Each request runs to completion through a single-port pixel store that
// takes one access per cycle, and in_stall stays high meanwhile. A line or
// fill writes (x_last-x_first+1) pixels on each row, a scroll reads and then
// writes each copied pixel before it fills the vacated rows, and clear
// writes min(width*height,8192) words. After reset the store is swept to
// zero, all 8192 words, one word per cycle, before the first request is
// taken; configuration writes are taken throughout. A finished result may
// wait in the output register while the next request is taken.
`default_nettype none

module framebuffer_region_engine_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fre_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [fre_pkg::X_W-1:0]       in_x_first,
  input  wire logic [fre_pkg::Y_W-1:0]       in_y_first,
  input  wire logic [fre_pkg::X_W-1:0]       in_x_last,
  input  wire logic [fre_pkg::Y_W-1:0]       in_y_last,
  input  wire logic [fre_pkg::Y_W-1:0]       in_shift_rows,
  input  wire logic [fre_pkg::COLOR_W-1:0]   in_pixel_color,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic      [fre_pkg::COLOR_W-1:0]   out_read_color,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fre_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [fre_pkg::X_W-1:0]       cfg_data
);

  localparam int XW = fre_pkg::X_W;
  localparam int YW = fre_pkg::Y_W;
  localparam int CW = fre_pkg::COLOR_W;
  localparam int NW = fre_pkg::CNT_W;

  // configuration registers
  logic [XW-1:0] width_r;
  logic [YW-1:0] height_r;
  logic [XW-1:0] pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= XW'(fre_pkg::MAX_WIDTH);
      height_r <= YW'(fre_pkg::MAX_HEIGHT);
      pitch_r  <= XW'(fre_pkg::MAX_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fre_pkg::REG_WIDTH:  width_r  <= cfg_data;
        fre_pkg::REG_HEIGHT: height_r <= cfg_data[YW-1:0];
        fre_pkg::REG_PITCH:  pitch_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // sequencer state
  fre_pkg::state_t state_r, state_nxt;
  logic [XW-1:0] x1_r, x1_nxt, x2_r, x2_nxt, cx_r, cx_nxt;
  logic [YW-1:0] cy_r, cy_nxt, ye_r, ye_nxt, n_r, n_nxt;
  logic [YW-1:0] fill_lo_r, fill_lo_nxt, fill_hi_r, fill_hi_nxt;
  logic          up_r, up_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [NW-1:0] lin_r, lin_nxt, cnt_r, cnt_nxt;
  logic          res_status_r, res_status_nxt;
  logic [CW-1:0] res_color_r, res_color_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [CW-1:0] out_color_r, out_color_nxt;

  fre_pkg::mem_req_t req;
  logic [CW-1:0]     rdata;

  fre_store u_store (
    .clk   (clk),
    .req   (req),
    .pitch (pitch_r),
    .rdata (rdata)
  );

  // request decode
  logic              x1_ok, x2_ok, y1_ok, y2_ok, pix_ok, line_ok, rect_ok, big_shift;
  logic [YW:0]       rect_h;
  logic [fre_pkg::PROD_W-1:0] area;
  logic [NW-1:0]     clear_cnt;
  logic [YW-1:0]     src_row;

  assign x1_ok     = in_x_first < width_r;
  assign x2_ok     = in_x_last < width_r;
  assign y1_ok     = in_y_first < height_r;
  assign y2_ok     = in_y_last < height_r;
  assign pix_ok    = x1_ok && y1_ok;
  assign line_ok   = pix_ok && x2_ok && (in_x_first <= in_x_last);
  assign rect_ok   = line_ok && y2_ok && (in_y_first <= in_y_last);
  assign rect_h    = {1'b0, in_y_last} - {1'b0, in_y_first} + (YW+1)'(1);
  assign big_shift = {1'b0, in_shift_rows} >= rect_h;
  assign area      = fre_pkg::PROD_W'(width_r) * fre_pkg::PROD_W'(height_r);
  assign clear_cnt = (32'(area) >= fre_pkg::STORE_WORDS) ? NW'(fre_pkg::STORE_WORDS)
                                                         : NW'(area);
  assign src_row   = up_r ? (cy_r + n_r) : (cy_r - n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fre_pkg::ST_SWEEP;
      lin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lin_r       <= lin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r         <= x1_nxt;
    x2_r         <= x2_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    ye_r         <= ye_nxt;
    n_r          <= n_nxt;
    fill_lo_r    <= fill_lo_nxt;
    fill_hi_r    <= fill_hi_nxt;
    up_r         <= up_nxt;
    col_r        <= col_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_color_r  <= res_color_nxt;
    out_status_r <= out_status_nxt;
    out_color_r  <= out_color_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    ye_nxt         = ye_r;
    n_nxt          = n_r;
    fill_lo_nxt    = fill_lo_r;
    fill_hi_nxt    = fill_hi_r;
    up_nxt         = up_r;
    col_nxt        = col_r;
    lin_nxt        = lin_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_color_nxt  = res_color_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_color_nxt  = out_color_r;

    req          = '0;
    req.row      = cy_r;
    req.column   = cx_r;
    req.lin_addr = lin_r[fre_pkg::ADDR_W-1:0];
    req.wdata    = col_r;

    unique case (state_r)
      fre_pkg::ST_SWEEP: begin
        req.wr    = 1'b1;
        req.lin   = 1'b1;
        req.wdata = '0;
        lin_nxt   = lin_r + NW'(1);
        if (lin_r == NW'(fre_pkg::STORE_WORDS - 1)) begin
          state_nxt = fre_pkg::ST_IDLE;
        end
      end

      fre_pkg::ST_IDLE: begin
        if (in_valid) begin
          x1_nxt         = in_x_first;
          x2_nxt         = in_x_last;
          cx_nxt         = in_x_first;
          cy_nxt         = in_y_first;
          ye_nxt         = in_y_first;
          n_nxt          = in_shift_rows;
          up_nxt         = (in_cmd == fre_pkg::CMD_SC_UP);
          col_nxt        = in_pixel_color;
          lin_nxt        = '0;
          cnt_nxt        = clear_cnt;
          res_status_nxt = fre_pkg::STATUS_DONE;
          res_color_nxt  = '0;
          state_nxt      = fre_pkg::ST_DONE;
          unique case (in_cmd)
            fre_pkg::CMD_PUT: begin
              x2_nxt = in_x_first;
              if (pix_ok) state_nxt = fre_pkg::ST_FILL;
            end
            fre_pkg::CMD_HLINE: begin
              if (line_ok) state_nxt = fre_pkg::ST_FILL;
              else res_status_nxt = fre_pkg::STATUS_REJECT;
            end
            fre_pkg::CMD_SC_UP, fre_pkg::CMD_SC_DN: begin
              if (!rect_ok) begin
                res_status_nxt = fre_pkg::STATUS_REJECT;
              end else if (big_shift) begin
                ye_nxt    = in_y_last;
                state_nxt = fre_pkg::ST_FILL;
              end else if (in_shift_rows != '0) begin
                state_nxt = fre_pkg::ST_COPY_RD;
                if (in_cmd == fre_pkg::CMD_SC_UP) begin
                  ye_nxt      = in_y_last - in_shift_rows;
                  fill_lo_nxt = in_y_last - in_shift_rows + YW'(1);
                  fill_hi_nxt = in_y_last;
                end else begin
                  // walk rows from the bottom up so sources are read first
                  cy_nxt      = in_y_last;
                  ye_nxt      = in_y_first + in_shift_rows;
                  fill_lo_nxt = in_y_first;
                  fill_hi_nxt = in_y_first + in_shift_rows - YW'(1);
                end
              end
            end
            fre_pkg::CMD_CLEAR: begin
              if (clear_cnt != '0) state_nxt = fre_pkg::ST_CLEAR;
            end
            fre_pkg::CMD_READ: begin
              if (pix_ok) state_nxt = fre_pkg::ST_READ;
            end
            default: begin
              res_status_nxt = fre_pkg::STATUS_REJECT;
            end
          endcase
        end
      end

      fre_pkg::ST_FILL: begin
        req.wr = 1'b1;
        if (cx_r == x2_r) begin
          cx_nxt = x1_r;
          if (cy_r == ye_r) state_nxt = fre_pkg::ST_DONE;
          else cy_nxt = cy_r + YW'(1);
        end else begin
          cx_nxt = cx_r + XW'(1);
        end
      end

      fre_pkg::ST_COPY_RD: begin
        req.rd    = 1'b1;
        req.row   = src_row;
        state_nxt = fre_pkg::ST_COPY_WR;
      end

      fre_pkg::ST_COPY_WR: begin
        req.wr    = 1'b1;
        req.wdata = rdata;
        state_nxt = fre_pkg::ST_COPY_RD;
        if (cx_r == x2_r) begin
          cx_nxt = x1_r;
          if (cy_r == ye_r) begin
            // copy finished, fill the vacated rows
            cy_nxt    = fill_lo_r;
            ye_nxt    = fill_hi_r;
            state_nxt = fre_pkg::ST_FILL;
          end else begin
            cy_nxt = up_r ? (cy_r + YW'(1)) : (cy_r - YW'(1));
          end
        end else begin
          cx_nxt = cx_r + XW'(1);
        end
      end

      fre_pkg::ST_CLEAR: begin
        req.wr  = 1'b1;
        req.lin = 1'b1;
        lin_nxt = lin_r + NW'(1);
        if (lin_r + NW'(1) == cnt_r) state_nxt = fre_pkg::ST_DONE;
      end

      fre_pkg::ST_READ: begin
        req.rd    = 1'b1;
        state_nxt = fre_pkg::ST_READ_WAIT;
      end

      fre_pkg::ST_READ_WAIT: begin
        res_color_nxt = rdata;
        state_nxt     = fre_pkg::ST_DONE;
      end

      fre_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_color_nxt  = res_color_r;
          state_nxt      = fre_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fre_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall       = (state_r != fre_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_color = out_color_r;

`include "framebuffer_region_engine_top_assert.svh"

  `FRE_ASSERT_NEXT(a_accept_goes_busy, in_valid && !in_stall, in_stall)
  `FRE_ASSERT_NEXT(a_sweep_once, state_r != fre_pkg::ST_SWEEP, state_r != fre_pkg::ST_SWEEP)
  `FRE_ASSERT_SAME(a_result_from_done, $rose(out_valid_r), $past(state_r) == fre_pkg::ST_DONE)
  `FRE_ASSERT_SAME(a_copy_write_after_read, state_r == fre_pkg::ST_COPY_WR, $past(state_r) == fre_pkg::ST_COPY_RD)

endmodule

`default_nettype wire
